// ===== rtl/rmez_pkg.sv =====
// shared constants and the arctangent table for the euler angle pipeline
package rmez_pkg;

    localparam int SCALED_W    = 33;  // scaled operand width, also holds the unsigned root
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 36;
    localparam int SQRT_LAT    = ROOT_W;
    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_LAT  = CORDIC_STEPS + 2;
    localparam int CX_W        = 36;
    localparam int CZ_W        = 20;
    localparam int ANGLE_W     = 16;
    localparam int PITCH_W     = 15;
    localparam int THR_W       = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd16382;
    localparam int HALF_PI_Q16 = 102944;
    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;

    localparam logic signed [CZ_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2, 20'sd1
    };

endpackage

// ===== rtl/rmez_sqrt.sv =====
// pipelined restoring integer square root, one result bit per stage
module rmez_sqrt import rmez_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad_in,
    output logic [ROOT_W-1:0] root_out
);

    logic [RAD_W-1:0]  rad_reg  [SQRT_LAT];
    logic [REM_W-1:0]  rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_cur;
        logic [REM_W-1:0]  rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (k == 0) begin : g_first
            assign rad_cur  = rad_in;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end else begin : g_next
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
        end

        // bring down the next two radicand bits
        assign rem_sh = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
        assign trial  = {(REM_W-2)'(root_cur), 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k] <= {rad_cur[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_cur[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_cur[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root_out = root_reg[SQRT_LAT-1];

endmodule

// ===== rtl/rmez_cordic.sv =====
// pipelined cordic vectoring atan2, q3.13 result clamped to +/- pi
module rmez_cordic import rmez_pkg::*; (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [SCALED_W-1:0] y_in,
    input  logic signed [SCALED_W-1:0] x_in,
    output logic signed [ANGLE_W-1:0]  z_out
);

    logic signed [CX_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                   zero_reg [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] z_out_reg;

    logic signed [CX_W-1:0] xe, ye;
    logic signed [CZ_W-1:0] zr;

    assign xe = CX_W'(x_in);
    assign ye = CX_W'(y_in);

    // left half plane is turned by a quarter first
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (xe < 0) begin
                if (ye >= 0) begin
                    x_reg[0] <= ye;
                    y_reg[0] <= -xe;
                    z_reg[0] <= CZ_W'(HALF_PI_Q16);
                end else begin
                    x_reg[0] <= -ye;
                    y_reg[0] <= xe;
                    z_reg[0] <= -CZ_W'(HALF_PI_Q16);
                end
            end else begin
                x_reg[0] <= xe;
                y_reg[0] <= ye;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign zr = (z_reg[CORDIC_STEPS] + CZ_W'(4)) >>> 3;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[CORDIC_STEPS]) begin
                z_out_reg <= '0;
            end else if (zr > CZ_W'(PI_Q13)) begin
                z_out_reg <= ANGLE_W'(PI_Q13);
            end else if (zr < -CZ_W'(PI_Q13)) begin
                z_out_reg <= -ANGLE_W'(PI_Q13);
            end else begin
                z_out_reg <= ANGLE_W'(zr);
            end
        end
    end

    assign z_out = z_out_reg;

endmodule

// ===== rtl/rotation_matrix_to_euler_zyx.sv =====
// rotation matrix to zyx euler angles, top level
//
//  channel  direction  ports
//  input    in         s_valid s_ready s_m00 s_m01 s_m10 s_m11 s_m20 s_m21 s_m22
//  result   out        m_valid m_ready m_roll_angle m_pitch_angle m_yaw_angle m_gimbal_lock
//  config   in         cfg_we cfg_wdata (gimbal threshold)
//
// one matrix per cycle while the pipeline advances; 54 register stages:
// squares, sum, 32 square root stages, 19 cordic stages and the output register
// the pipeline advances as a whole whenever the output register is empty or taken
// reset clears valid bits and loads the threshold with 16382
module rotation_matrix_to_euler_zyx import rmez_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [THR_W-1:0]               cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m00,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m01,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m10,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m11,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m20,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m21,
    input  logic signed [SAMPLE_WIDTH-1:0] s_m22,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [ANGLE_W-1:0]      m_roll_angle,
    output logic signed [PITCH_W-1:0]      m_pitch_angle,
    output logic signed [ANGLE_W-1:0]      m_yaw_angle,
    output logic                           m_gimbal_lock
);

    localparam int SW       = SAMPLE_WIDTH;
    localparam int PRESCALE = 32 - SW;
    localparam int SQ_W     = 2 * SW;
    localparam int CMP_W    = SW + 16;
    localparam int TOT_LAT  = SQRT_LAT + CORDIC_LAT;

    typedef struct packed {
        logic signed [SCALED_W-1:0] ry;
        logic signed [SCALED_W-1:0] rx;
        logic signed [SCALED_W-1:0] yy;
        logic signed [SCALED_W-1:0] yx;
        logic signed [SCALED_W-1:0] py;
        logic                       lock;
        logic                       neg;
    } side_t;

    logic en;
    logic [THR_W-1:0] thr_reg;

    logic              a_valid_reg, b_valid_reg;
    logic [SQ_W-1:0]   a_sq0_reg, a_sq1_reg, b_sum_reg;
    side_t             a_side_reg, b_side_reg, a_side_next;
    side_t             side_reg [SQRT_LAT];
    logic              vld_reg  [TOT_LAT];
    logic              lock_reg [TOT_LAT];
    logic              neg_reg  [TOT_LAT];

    logic signed [SQ_W-1:0] p0, p1;
    logic signed [SW:0]     m20e, mag;
    logic [ROOT_W-1:0]      root;
    logic signed [ANGLE_W-1:0] roll_z, pitch_z, yaw_z;

    logic                       m_valid_reg;
    logic signed [ANGLE_W-1:0]  roll_reg, yaw_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic                       lock_out_reg;

    function automatic logic signed [SCALED_W-1:0] scale(input logic signed [SW-1:0] v);
        scale = SCALED_W'(v) <<< PRESCALE;
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    assign p0   = SQ_W'(s_m00) * SQ_W'(s_m00);
    assign p1   = SQ_W'(s_m10) * SQ_W'(s_m10);
    assign m20e = (SW+1)'(s_m20);
    assign mag  = (m20e < 0) ? -m20e : m20e;

    // gimbal lock swaps the roll operands for m01, m11
    always_comb begin
        a_side_next.lock = CMP_W'($unsigned(mag)) >= CMP_W'(thr_reg);
        a_side_next.neg  = s_m20[SW-1];
        a_side_next.ry   = a_side_next.lock ? scale(s_m01) : scale(s_m21);
        a_side_next.rx   = a_side_next.lock ? scale(s_m11) : scale(s_m22);
        a_side_next.yy   = scale(s_m10);
        a_side_next.yx   = scale(s_m00);
        a_side_next.py   = -scale(s_m20);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int k = 0; k < TOT_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            vld_reg[0]  <= b_valid_reg;
            for (int k = 1; k < TOT_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sq0_reg   <= $unsigned(p0);
            a_sq1_reg   <= $unsigned(p1);
            a_side_reg  <= a_side_next;
            b_sum_reg   <= a_sq0_reg + a_sq1_reg;
            b_side_reg  <= a_side_reg;
            side_reg[0] <= b_side_reg;
            lock_reg[0] <= b_side_reg.lock;
            neg_reg[0]  <= b_side_reg.neg;
            for (int k = 1; k < SQRT_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 1; k < TOT_LAT; k++) begin
                lock_reg[k] <= lock_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    rmez_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (RAD_W'(b_sum_reg) << (2 * PRESCALE)),
        .root_out (root)
    );

    rmez_cordic u_roll (
        .aclk  (aclk),
        .en    (en),
        .y_in  (side_reg[SQRT_LAT-1].ry),
        .x_in  (side_reg[SQRT_LAT-1].rx),
        .z_out (roll_z)
    );

    rmez_cordic u_pitch (
        .aclk  (aclk),
        .en    (en),
        .y_in  (side_reg[SQRT_LAT-1].py),
        .x_in  (signed'(SCALED_W'(root))),
        .z_out (pitch_z)
    );

    rmez_cordic u_yaw (
        .aclk  (aclk),
        .en    (en),
        .y_in  (side_reg[SQRT_LAT-1].yy),
        .x_in  (side_reg[SQRT_LAT-1].yx),
        .z_out (yaw_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[TOT_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lock_out_reg <= lock_reg[TOT_LAT-1];
            if (lock_reg[TOT_LAT-1]) begin
                yaw_reg <= '0;
                if (neg_reg[TOT_LAT-1]) begin
                    pitch_reg <= PITCH_W'(HALF_PI_Q13);
                    roll_reg  <= roll_z;
                end else begin
                    pitch_reg <= -PITCH_W'(HALF_PI_Q13);
                    roll_reg  <= -roll_z;
                end
            end else begin
                yaw_reg  <= yaw_z;
                roll_reg <= roll_z;
                if (pitch_z > ANGLE_W'(HALF_PI_Q13)) begin
                    pitch_reg <= PITCH_W'(HALF_PI_Q13);
                end else if (pitch_z < -ANGLE_W'(HALF_PI_Q13)) begin
                    pitch_reg <= -PITCH_W'(HALF_PI_Q13);
                end else begin
                    pitch_reg <= PITCH_W'(pitch_z);
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_roll_angle  = roll_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_yaw_angle   = yaw_reg;
    assign m_gimbal_lock = lock_out_reg;

endmodule
